>>> hdl/multi_key_debounce_long_press_core_assert.svh
// assertion macros for the key scanner
`ifndef MULTI_KEY_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH
`define MULTI_KEY_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH

// same-cycle implication
`define MKDLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MKDLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mkdlp_pkg.sv
package mkdlp_pkg;

    localparam int TIME_W = 32;
    localparam int MASK_W = 8;
    localparam int CFG_AW = 3;

    localparam logic [CFG_AW-1:0] CFG_DEBOUNCE    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_LONG_PRESS  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_REPEAT      = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_CANCEL      = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_ENABLE_MASK = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_ACTIVE_LOW  = 3'd5;

    typedef enum logic [1:0] {
        EV_PRESS        = 2'd0,
        EV_RELEASE      = 2'd1,
        EV_LONG_RELEASE = 2'd2,
        EV_LONG_REPEAT  = 2'd3
    } t_event_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DIFF,
        S_DEB,
        S_PRESS_DUE,
        S_RCMP,
        S_HELD,
        S_CANCEL,
        S_LONG,
        S_REP_DUE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic              sub;
    } t_alu_req;

endpackage

>>> hdl/mkdlp_addsub.sv
module mkdlp_addsub
    import mkdlp_pkg::*;
(
    input  t_alu_req          i_req,
    output logic [TIME_W-1:0] o_sum,
    output logic              o_carry
);

    logic [TIME_W-1:0] w_b;
    logic [TIME_W:0]   w_full;

    // a - b as a + ~b + 1, carry out set when a >= b
    assign w_b    = i_req.sub ? ~i_req.b : i_req.b;
    assign w_full = {1'b0, i_req.a} + {1'b0, w_b} + (TIME_W+1)'(i_req.sub);
    assign o_sum   = w_full[TIME_W-1:0];
    assign o_carry = w_full[TIME_W];

endmodule

>>> hdl/multi_key_debounce_long_press_core.sv
// channel | direction | handshake                   | payload
// tick    | in        | i_in_valid / o_in_ready     | i_tick_time, i_pin_levels
// event   | out       | o_out_valid / i_out_ready   | o_key_index, o_event_kind
// config  | in        | i_cfg_we                    | i_cfg_addr, i_cfg_wdata
// a request is captured, then the keys are scanned in turn until an event is found or the last key is done
// the key that gives the event ends the scan, and no new request is taken before the scan ends
// all time arithmetic goes through the single shared 32-bit add/compare unit
// reset is synchronous and active low, it clears all key state, config, scan state and output valid
// the event sits in an output register, a new request is taken while it waits
// a scan that finds an event while the output is still full waits for it to drain
module multi_key_debounce_long_press_core
    import mkdlp_pkg::*;
#(
    parameter int NUM_KEYS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [TIME_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [TIME_W-1:0] i_tick_time,
    input  logic [MASK_W-1:0] i_pin_levels,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_key_index,
    output logic [1:0]        o_event_kind
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

    logic [TIME_W-1:0] r_debounce, r_long_press, r_repeat, r_cancel;
    logic [MASK_W-1:0] r_en_mask, r_al_mask;

    logic [TIME_W-1:0] r_now;
    logic [MASK_W-1:0] r_pins;

    logic [NUM_KEYS-1:0] r_seen, r_stable_lv, r_pending_lv;
    logic [TIME_W-1:0]   r_change [NUM_KEYS];
    logic [TIME_W-1:0]   r_press  [NUM_KEYS];
    logic [TIME_W-1:0]   r_due    [NUM_KEYS];

    t_state            r_state, n_state;
    logic [KW-1:0]     r_key, n_key;
    logic [TIME_W-1:0] r_tmp, n_tmp;
    t_event_kind       r_kind, n_kind;
    logic              r_rep, n_rep;

    logic              r_out_valid;
    logic [2:0]        r_out_key;
    t_event_kind       r_out_kind;

    logic [NUM_KEYS-1:0] w_en_vec, w_al_vec, w_pin_vec;
    logic                w_en, w_pressed;
    logic                w_clr, w_first, w_pend_upd, w_set_stable, w_press_we, w_due_we;
    logic [TIME_W-1:0]   w_due_val;
    logic                w_load_out;
    logic [31:0]         w_key_ext;

    t_alu_req          w_alu;
    logic [TIME_W-1:0] w_sum;
    logic              w_ge;

    mkdlp_addsub u_addsub (
        .i_req   (w_alu),
        .o_sum   (w_sum),
        .o_carry (w_ge)
    );

    // keys past the mask width count as disabled
    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            w_en_vec[k]  = (k < MASK_W) ? r_en_mask[k[2:0]] : 1'b0;
            w_al_vec[k]  = (k < MASK_W) ? r_al_mask[k[2:0]] : 1'b0;
            w_pin_vec[k] = (k < MASK_W) ? r_pins[k[2:0]]    : 1'b0;
        end
    end

    assign w_en      = w_en_vec[r_key];
    assign w_pressed = w_pin_vec[r_key] ^ w_al_vec[r_key];
    assign w_key_ext = 32'(r_key);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_tmp        = r_tmp;
        n_kind       = r_kind;
        n_rep        = r_rep;
        w_clr        = 1'b0;
        w_first      = 1'b0;
        w_pend_upd   = 1'b0;
        w_set_stable = 1'b0;
        w_press_we   = 1'b0;
        w_due_we     = 1'b0;
        w_due_val    = w_sum;
        w_load_out   = 1'b0;
        w_alu.a      = r_now;
        w_alu.b      = r_tmp;
        w_alu.sub    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOAD;
                    n_key   = '0;
                end
            end
            S_LOAD: begin
                if (!w_en || !r_seen[r_key]) begin
                    w_clr   = !w_en;
                    w_first = w_en;
                    if (r_key == LAST_KEY) begin
                        n_state = S_IDLE;
                    end else begin
                        n_key = r_key + 1'b1;
                    end
                end else begin
                    w_pend_upd = (w_pressed != r_pending_lv[r_key]);
                    n_state    = S_DIFF;
                end
            end
            S_DIFF: begin
                w_alu.b = r_change[r_key];
                n_tmp   = w_sum;
                n_state = S_DEB;
            end
            S_DEB: begin
                w_alu.a = r_tmp;
                w_alu.b = r_debounce;
                if ((r_pending_lv[r_key] != r_stable_lv[r_key]) && w_ge) begin
                    w_set_stable = 1'b1;
                    if (r_pending_lv[r_key]) begin
                        w_press_we = 1'b1;
                        n_state    = S_PRESS_DUE;
                    end else begin
                        n_rep   = 1'b0;
                        n_state = S_HELD;
                    end
                end else if (r_stable_lv[r_key] && (r_due[r_key] != '0)) begin
                    n_state = S_RCMP;
                end else if (r_key == LAST_KEY) begin
                    n_state = S_IDLE;
                end else begin
                    n_key   = r_key + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_PRESS_DUE: begin
                w_alu.b   = r_long_press;
                w_alu.sub = 1'b0;
                w_due_we  = 1'b1;
                n_kind    = EV_PRESS;
                n_state   = S_EMIT;
            end
            S_RCMP: begin
                w_alu.b = r_due[r_key];
                if (w_ge) begin
                    n_rep   = 1'b1;
                    n_state = S_HELD;
                end else if (r_key == LAST_KEY) begin
                    n_state = S_IDLE;
                end else begin
                    n_key   = r_key + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_HELD: begin
                w_alu.b = r_press[r_key];
                n_tmp   = w_sum;
                n_state = S_CANCEL;
            end
            S_CANCEL: begin
                w_alu.a = r_tmp;
                w_alu.b = r_cancel;
                if ((r_cancel != '0) && w_ge) begin
                    // swallowed, scan goes on
                    w_due_we  = r_rep;
                    w_due_val = '0;
                    if (r_key == LAST_KEY) begin
                        n_state = S_IDLE;
                    end else begin
                        n_key   = r_key + 1'b1;
                        n_state = S_LOAD;
                    end
                end else if (r_rep) begin
                    n_state = S_REP_DUE;
                end else begin
                    n_state = S_LONG;
                end
            end
            S_LONG: begin
                w_alu.a = r_tmp;
                w_alu.b = r_long_press;
                n_kind  = w_ge ? EV_LONG_RELEASE : EV_RELEASE;
                n_state = S_EMIT;
            end
            S_REP_DUE: begin
                w_alu.b   = r_repeat;
                w_alu.sub = 1'b0;
                w_due_we  = 1'b1;
                n_kind    = EV_LONG_REPEAT;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key   <= '0;
            r_rep   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_key   <= n_key;
            r_rep   <= n_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tmp  <= n_tmp;
        r_kind <= n_kind;
        if (i_in_valid && o_in_ready) begin
            r_now  <= i_tick_time;
            r_pins <= i_pin_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= '0;
            r_long_press <= '0;
            r_repeat     <= '0;
            r_cancel     <= '0;
            r_en_mask    <= '0;
            r_al_mask    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DEBOUNCE:    r_debounce   <= i_cfg_wdata;
                CFG_LONG_PRESS:  r_long_press <= i_cfg_wdata;
                CFG_REPEAT:      r_repeat     <= i_cfg_wdata;
                CFG_CANCEL:      r_cancel     <= i_cfg_wdata;
                CFG_ENABLE_MASK: r_en_mask    <= i_cfg_wdata[MASK_W-1:0];
                CFG_ACTIVE_LOW:  r_al_mask    <= i_cfg_wdata[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // per-key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= '0;
            r_stable_lv  <= '0;
            r_pending_lv <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_change[k] <= '0;
                r_press[k]  <= '0;
                r_due[k]    <= '0;
            end
        end else begin
            if (w_clr) begin
                r_seen[r_key]       <= 1'b0;
                r_stable_lv[r_key]  <= 1'b0;
                r_pending_lv[r_key] <= 1'b0;
                r_change[r_key]     <= '0;
                r_press[r_key]      <= '0;
                r_due[r_key]        <= '0;
            end
            if (w_first) begin
                r_seen[r_key]       <= 1'b1;
                r_stable_lv[r_key]  <= w_pressed;
                r_pending_lv[r_key] <= w_pressed;
                r_change[r_key]     <= r_now;
            end
            if (w_pend_upd) begin
                r_pending_lv[r_key] <= w_pressed;
                r_change[r_key]     <= r_now;
            end
            if (w_set_stable) begin
                r_stable_lv[r_key] <= r_pending_lv[r_key];
            end
            if (w_press_we) begin
                r_press[r_key] <= r_now;
            end
            if (w_due_we) begin
                r_due[r_key] <= w_due_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_key  <= w_key_ext[2:0];
            r_out_kind <= r_kind;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_key_index  = r_out_key;
    assign o_event_kind = r_out_kind;

`include "multi_key_debounce_long_press_core_assert.svh"

    `MKDLP_ASSERT_NXT(a_scan_start, i_in_valid && o_in_ready, r_state == S_LOAD && r_key == '0, "scan did not start at first key")
    `MKDLP_ASSERT_IMP(a_stable_seen, 1'b1, (r_stable_lv & ~r_seen) == '0, "stable level set on unseen key")
    `MKDLP_ASSERT_IMP(a_out_from_emit, $rose(o_out_valid), $past(r_state) == S_EMIT, "event shown outside emit")

endmodule

>>> bench/tb_multi_key_debounce_long_press_core.sv
`timescale 1ns / 1ps

module tb_multi_key_debounce_long_press_core;
    import mkdlp_pkg::*;

    localparam int NUM_KEYS  = 8;
    localparam int SCAN_WAIT = 6 * NUM_KEYS + 16;
    localparam int MAX_SHOWN = 40;

    typedef struct packed {
        logic [2:0]  key;
        t_event_kind kind;
    } t_key_event;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [TIME_W-1:0] i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [TIME_W-1:0] i_tick_time = '0;
    logic [MASK_W-1:0] i_pin_levels = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [2:0]        o_key_index;
    logic [1:0]        o_event_kind;

    // scanner registers as last written
    logic [TIME_W-1:0] deb_ms = '0;
    logic [TIME_W-1:0] long_ms = '0;
    logic [TIME_W-1:0] rep_ms = '0;
    logic [TIME_W-1:0] drop_ms = '0;
    logic [MASK_W-1:0] enable_bits = '0;
    logic [MASK_W-1:0] low_bits = '0;

    // per-key debounce state, levels mean pressed
    logic [NUM_KEYS-1:0] key_seen = '0;
    logic [NUM_KEYS-1:0] key_stable = '0;
    logic [NUM_KEYS-1:0] key_pending = '0;
    logic [TIME_W-1:0]   change_at [NUM_KEYS] = '{default: '0};
    logic [TIME_W-1:0]   pressed_at [NUM_KEYS] = '{default: '0};
    logic [TIME_W-1:0]   repeat_at [NUM_KEYS] = '{default: '0};

    t_key_event        due_events [$];
    logic [TIME_W-1:0] now_ms = '0;
    logic [MASK_W-1:0] pin_state = '0;
    bit                gaps_on = 1'b1;
    int                error_count = 0;
    int                tick_count = 0;
    int                settings_count = 0;
    int                kind_seen [4] = '{default: 0};
    int                stall_left = 0;

    multi_key_debounce_long_press_core #(
        .NUM_KEYS(NUM_KEYS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_tick_time (i_tick_time),
        .i_pin_levels(i_pin_levels),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_key_index (o_key_index),
        .o_event_kind(o_event_kind)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit scan_keys(input logic [TIME_W-1:0] now,
                                     input logic [MASK_W-1:0] pins,
                                     output t_key_event ev);
        logic              pressed;
        logic [TIME_W-1:0] held;
        ev = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (k >= MASK_W || !enable_bits[k]) begin
                key_seen[k]    = 1'b0;
                key_stable[k]  = 1'b0;
                key_pending[k] = 1'b0;
                change_at[k]   = '0;
                pressed_at[k]  = '0;
                repeat_at[k]   = '0;
                continue;
            end
            pressed = pins[k] ^ low_bits[k];
            if (!key_seen[k]) begin
                key_seen[k]    = 1'b1;
                key_stable[k]  = pressed;
                key_pending[k] = pressed;
                change_at[k]   = now;
                continue;
            end
            if (pressed != key_pending[k]) begin
                key_pending[k] = pressed;
                change_at[k]   = now;
            end
            if (key_pending[k] != key_stable[k] && TIME_W'(now - change_at[k]) >= deb_ms) begin
                key_stable[k] = key_pending[k];
                ev.key = 3'(k);
                if (key_stable[k]) begin
                    pressed_at[k] = now;
                    repeat_at[k]  = now + long_ms;
                    ev.kind = EV_PRESS;
                    return 1'b1;
                end
                held = now - pressed_at[k];
                if (drop_ms != 0 && held >= drop_ms)
                    continue;
                if (held >= long_ms)
                    ev.kind = EV_LONG_RELEASE;
                else
                    ev.kind = EV_RELEASE;
                return 1'b1;
            end
            if (key_stable[k] && repeat_at[k] != 0 && now >= repeat_at[k]) begin
                held = now - pressed_at[k];
                if (drop_ms != 0 && held >= drop_ms) begin
                    repeat_at[k] = '0;
                    continue;
                end
                repeat_at[k] = now + rep_ms;
                ev.key  = 3'(k);
                ev.kind = EV_LONG_REPEAT;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_SHOWN)
            $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // drop valid and wait until every predicted event has been taken
    task automatic hold_until_quiet();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_events.size() != 0);
    endtask

    task automatic load_regs(input logic [TIME_W-1:0] deb, input logic [TIME_W-1:0] lng,
                             input logic [TIME_W-1:0] rep, input logic [TIME_W-1:0] cxl,
                             input logic [MASK_W-1:0] en, input logic [MASK_W-1:0] al);
        logic [CFG_AW-1:0] addrs [6];
        logic [TIME_W-1:0] vals [6];
        addrs = '{CFG_DEBOUNCE, CFG_LONG_PRESS, CFG_REPEAT, CFG_CANCEL,
                  CFG_ENABLE_MASK, CFG_ACTIVE_LOW};
        vals  = '{deb, lng, rep, cxl, TIME_W'(en), TIME_W'(al)};
        hold_until_quiet();
        // a scan that ends without an event may still be running
        repeat (SCAN_WAIT) @(posedge i_clk);
        for (int i = 0; i < 6; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= addrs[i];
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b0;
        deb_ms      = deb;
        long_ms     = lng;
        rep_ms      = rep;
        drop_ms     = cxl;
        enable_bits = en;
        low_bits    = al;
        settings_count++;
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] t, input logic [MASK_W-1:0] pins);
        t_key_event ev;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_tick_time  <= t;
        i_pin_levels <= pins;
        do @(posedge i_clk); while (!o_in_ready);
        if (scan_keys(t, pins, ev))
            due_events.push_back(ev);
        tick_count++;
    endtask

    task automatic run_random_ticks(input int count, input int wild_pct);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < wild_pct) begin
                now_ms = $urandom;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1: now_ms += $urandom_range(0, 200);
                    2: ;
                    default: now_ms += $urandom_range(1, 3);
                endcase
            end
            pin_state ^= MASK_W'($urandom & $urandom & $urandom);
            if ($urandom_range(0, 29) == 0)
                pin_state = MASK_W'($urandom);
            send_tick(now_ms, pin_state);
            if (gaps_on && (n == count / 2 || $urandom_range(0, 59) == 0))
                hold_until_quiet();
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left == 0 && gaps_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 11);
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_key_event want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_events.size() == 0) begin
                report_mismatch($sformatf("key %0d kind %0d with no event predicted",
                                          o_key_index, o_event_kind));
            end else begin
                want = due_events.pop_front();
                kind_seen[want.kind]++;
                if (o_key_index !== want.key)
                    report_mismatch($sformatf("key index %0d, predicted %0d",
                                              o_key_index, want.key));
                if (o_event_kind !== want.kind)
                    report_mismatch($sformatf("key %0d kind %0d, predicted %s",
                                              want.key, o_event_kind, want.kind.name()));
            end
        end
    end

    task automatic test_unconfigured_keys();
        send_tick(32'd50, 8'hFF);
        send_tick(32'd51, 8'h00);
    endtask

    task automatic test_press_release_repeat();
        load_regs(32'd2, 32'd10, 32'd4, 32'd0, 8'hFF, 8'h00);
        send_tick(32'd100, 8'h00);
        send_tick(32'd101, 8'h01);
        send_tick(32'd103, 8'h01);
        send_tick(32'd105, 8'h00);
        send_tick(32'd107, 8'h00);
        send_tick(32'd108, 8'h03);
        send_tick(32'd110, 8'h03);
        send_tick(32'd111, 8'h03);
        send_tick(32'd120, 8'h03);
        send_tick(32'd121, 8'h03);
        send_tick(32'd125, 8'h02);
        send_tick(32'd127, 8'h00);
    endtask

    task automatic test_cancel_hold();
        // key 7 is active low, pin high means released
        load_regs(32'd0, 32'd5, 32'd3, 32'd12, 8'h81, 8'h80);
        send_tick(32'd200, 8'h81);
        send_tick(32'd205, 8'h81);
        send_tick(32'd213, 8'h81);
        // swallowed release on key 0, scan goes on to key 7
        send_tick(32'd214, 8'h00);
    endtask

    task automatic test_extreme_registers();
        load_regs('1, '1, '1, '1, 8'hFF, 8'hFF);
        send_tick(32'hFFFF_FFF0, 8'hFF);
        send_tick(32'h0000_0005, 8'h00);
        // zero times across the counter wrap
        load_regs('0, '0, '0, '0, 8'h5A, 8'hA5);
        send_tick(32'hFFFF_FFFE, 8'h55);
        send_tick(32'hFFFF_FFFF, 8'hAA);
        send_tick(32'h0000_0000, 8'hAA);
        send_tick(32'h0000_0001, 8'h55);
    endtask

    task automatic test_random_short_times();
        load_regs($urandom_range(0, 4), $urandom_range(0, 30), $urandom_range(0, 8), '0,
                  8'hFF, MASK_W'($urandom));
        now_ms = 32'd1000;
        run_random_ticks(120, 1);
    endtask

    task automatic test_random_cancel();
        load_regs($urandom_range(0, 3), $urandom_range(3, 20), $urandom_range(1, 6),
                  $urandom_range(15, 60), MASK_W'($urandom) | 8'h01, MASK_W'($urandom));
        now_ms = 32'hFFFF_FF00;
        run_random_ticks(120, 1);
    endtask

    task automatic test_random_zero_times();
        load_regs('0, '0, '0, '0, 8'hFF, MASK_W'($urandom));
        now_ms = 32'hFFFF_FFC0;
        run_random_ticks(100, 2);
    endtask

    task automatic test_random_max_times();
        load_regs('1, '1, '1, '1, 8'hFF, MASK_W'($urandom));
        run_random_ticks(80, 50);
    endtask

    task automatic test_random_enable_churn();
        for (int r = 0; r < 4; r++) begin
            load_regs($urandom_range(0, 3), $urandom_range(5, 25), $urandom_range(1, 6),
                      (r % 2) ? TIME_W'($urandom_range(20, 50)) : '0,
                      MASK_W'($urandom), MASK_W'($urandom));
            run_random_ticks(30, 2);
        end
    endtask

    task automatic test_steady_stream();
        load_regs($urandom_range(0, 2), $urandom_range(4, 16), $urandom_range(1, 4),
                  $urandom_range(30, 80), 8'hFF, MASK_W'($urandom));
        run_random_ticks(150, 1);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_unconfigured_keys();
        test_press_release_repeat();
        test_cancel_hold();
        test_extreme_registers();
        test_random_short_times();
        test_random_cancel();
        test_random_zero_times();
        test_random_max_times();
        test_random_enable_churn();
        gaps_on = 1'b0;
        test_steady_stream();
        hold_until_quiet();
        repeat (SCAN_WAIT) @(posedge i_clk);
        $display("%0d ticks over %0d register settings, with wrap, cancel and disabled keys",
                 tick_count, settings_count);
        $display("events checked: %0d press, %0d release, %0d long release, %0d repeat",
                 kind_seen[EV_PRESS], kind_seen[EV_RELEASE], kind_seen[EV_LONG_RELEASE],
                 kind_seen[EV_LONG_REPEAT]);
        if (error_count == 0 && due_events.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d events outstanding", due_events.size());
        $display("Verification failed");
        $finish;
    end

endmodule
